[rtl/core/video_object_pixel_composer_defines.svh]
// assertion macros for the video object pixel composer
// used by the top level only, no other dependencies
`ifndef VIDEO_OBJECT_PIXEL_COMPOSER_DEFINES_SVH
`define VIDEO_OBJECT_PIXEL_COMPOSER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define VOPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define VOPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/vopc_pkg.sv]
// shared types, register map, copy table and palette for the pixel composer
// no dependencies
package vopc_pkg;

    localparam int LINE_WIDTH = 160;
    localparam int HALF_WIDTH = LINE_WIDTH / 2;
    localparam int NUM_REGS   = 25;

    localparam logic [7:0] BLANK_CODE = 8'h88;
    localparam logic [7:0] COPY_NONE  = 8'hFF;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_IDLE  = 2'd3
    } t_mode;

    // object register map
    localparam logic [4:0] REG_COLUP0 = 5'd0;
    localparam logic [4:0] REG_COLUP1 = 5'd1;
    localparam logic [4:0] REG_COLUPF = 5'd2;
    localparam logic [4:0] REG_COLUBK = 5'd3;
    localparam logic [4:0] REG_CTRLPF = 5'd4;
    localparam logic [4:0] REG_PF0    = 5'd5;
    localparam logic [4:0] REG_PF1    = 5'd6;
    localparam logic [4:0] REG_PF2    = 5'd7;
    localparam logic [4:0] REG_GRP0   = 5'd8;
    localparam logic [4:0] REG_GRP1   = 5'd9;
    localparam logic [4:0] REG_NUSIZ0 = 5'd10;
    localparam logic [4:0] REG_NUSIZ1 = 5'd11;
    localparam logic [4:0] REG_REFP0  = 5'd12;
    localparam logic [4:0] REG_REFP1  = 5'd13;
    localparam logic [4:0] REG_ENAM0  = 5'd14;
    localparam logic [4:0] REG_ENAM1  = 5'd15;
    localparam logic [4:0] REG_ENABL  = 5'd16;
    localparam logic [4:0] REG_RESMP0 = 5'd17;
    localparam logic [4:0] REG_RESMP1 = 5'd18;
    localparam logic [4:0] REG_VBLANK = 5'd19;
    localparam logic [4:0] REG_POSP0  = 5'd20;
    localparam logic [4:0] REG_POSP1  = 5'd21;
    localparam logic [4:0] REG_POSM0  = 5'd22;
    localparam logic [4:0] REG_POSM1  = 5'd23;
    localparam logic [4:0] REG_POSBL  = 5'd24;

    typedef logic [NUM_REGS-1:0][7:0] t_obj_regs;

    // objects present at one pixel, p0 in bit 0
    typedef struct packed {
        logic pf;
        logic bl;
        logic m1;
        logic m0;
        logic p1;
        logic p0;
    } t_hits;

    // copy start offsets per number/size code
    localparam logic [7:0] COPY_OFFS [8][3] = '{
        '{8'd0, COPY_NONE, COPY_NONE},
        '{8'd0, 8'd16,     COPY_NONE},
        '{8'd0, 8'd32,     COPY_NONE},
        '{8'd0, 8'd16,     8'd32},
        '{8'd0, 8'd64,     COPY_NONE},
        '{8'd0, COPY_NONE, COPY_NONE},
        '{8'd0, 8'd32,     8'd64},
        '{8'd0, COPY_NONE, COPY_NONE}
    };

    localparam logic [23:0] PALETTE [128] = '{
        24'h000000, 24'h1A1A1A, 24'h393939, 24'h5B5B5B,
        24'h7E7E7E, 24'hA2A2A2, 24'hC7C7C7, 24'hEDEDED,
        24'h160301, 24'h362006, 24'h594211, 24'h7D651E,
        24'hA2892B, 24'hC7AE39, 24'hEDD34B, 24'hFDFA66,
        24'h320402, 24'h561207, 24'h792E10, 24'h9D4F1C,
        24'hC27128, 24'hE7943B, 24'hF3B753, 24'hF9E080,
        24'h400704, 24'h69110A, 24'h8B2312, 24'hAF3E25,
        24'hD35D40, 24'hED7E60, 24'hF0A187, 24'hF5C8BD,
        24'h3E060B, 24'h651021, 24'h891C40, 24'hAC3362,
        24'hD05184, 24'hEC71A8, 24'hEF92D3, 24'hF3BAF2,
        24'h280347, 24'h4F0A63, 24'h721687, 24'h942EAB,
        24'hB84DD0, 24'hDD6DF7, 24'hEF90F0, 24'hF3B8F3,
        24'h0B007D, 24'h2E049B, 24'h4E15C1, 24'h6F32E7,
        24'h9252F5, 24'hB876F6, 24'hDF9CF8, 24'hF5C2F6,
        24'h00008B, 24'h0905B5, 24'h2722DB, 24'h4742F4,
        24'h6A64F5, 24'h8F8AF7, 24'hB6B0F8, 24'hDED8FB,
        24'h00006D, 24'h071BA4, 24'h173BCE, 24'h325DF4,
        24'h507FF6, 24'h73A4F7, 24'h98CCFA, 24'hBFF4FC,
        24'h031038, 24'h11306A, 24'h22549D, 24'h3577C2,
        24'h4D9BE7, 24'h6ABFF8, 24'h8BE6FB, 24'hAAFBFD,
        24'h081E05, 24'h194229, 24'h2C6758, 24'h3D8B7B,
        24'h53AE9E, 24'h6ED4C3, 24'h8DFBE9, 24'hA4FBFD,
        24'h0A2307, 24'h1D4913, 24'h2F6E21, 24'h43933B,
        24'h5BB75A, 24'h78DD7B, 24'h95FB9D, 24'hAFFBBB,
        24'h092005, 24'h1B4511, 24'h2F691B, 24'h498E27,
        24'h67B336, 24'h88D84C, 24'hAAFB68, 24'hC9FC7E,
        24'h041503, 24'h1B3509, 24'h3A5815, 24'h5C7D23,
        24'h80A230, 24'hA3C73D, 24'hC8ED51, 24'hECFD65,
        24'h170301, 24'h372006, 24'h5A4211, 24'h7E651E,
        24'hA3892B, 24'hC9AE39, 24'hEED34B, 24'hFDFA66,
        24'h330402, 24'h571207, 24'h7A2E11, 24'h9E4F1C,
        24'hC37028, 24'hE8943B, 24'hF3B753, 24'hF9E080
    };

    // bring a value below two line widths into the line
    function automatic logic [7:0] wrap_pos(input logic [8:0] v);
        logic [8:0] t;
        begin
            t = v - 9'(LINE_WIDTH);
            return (v >= 9'(LINE_WIDTH)) ? t[7:0] : v[7:0];
        end
    endfunction

endpackage

[rtl/core/vopc_if.sv]
// valid/ready channels for composer items and results
// no dependencies
interface vopc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] pixel_x;
    logic [4:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, mode, pixel_x, reg_index, write_data, input ready);
    modport sink   (input valid, mode, pixel_x, reg_index, write_data, output ready);
endinterface

interface vopc_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  color_code;
    logic [23:0] rgb_color;
    logic [5:0]  object_hits;
    logic [14:0] collision_latches;

    modport source (output valid, color_code, rgb_color, object_hits, collision_latches,
                    input ready);
    modport sink   (input valid, color_code, rgb_color, object_hits, collision_latches,
                    output ready);
endinterface

[rtl/core/vopc_regfile.sv]
// object register file, 25 bytes, cleared at reset
// depends on vopc_pkg
module vopc_regfile (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [4:0]           i_wr_index,
    input  logic [7:0]           i_wr_data,
    output vopc_pkg::t_obj_regs  o_regs
);
    import vopc_pkg::*;

    t_obj_regs r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else begin
            // indexes past the map match no entry and are dropped
            for (int i = 0; i < NUM_REGS; i++) begin
                if (i_wr_en && i_wr_index == 5'(i)) begin
                    r_regs[i] <= i_wr_data;
                end
            end
        end
    end

    assign o_regs = r_regs;

endmodule

[rtl/core/vopc_object_hit.sv]
// per-pixel hit detection for playfield, players, missiles and ball
// depends on vopc_pkg
module vopc_object_hit (
    input  vopc_pkg::t_obj_regs i_regs,
    input  logic [7:0]          i_x,
    output vopc_pkg::t_hits     o_hits
);
    import vopc_pkg::*;

    // distance from b forward to a around the line
    function automatic logic [7:0] wrap_diff(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] t;
        begin
            t = {1'b0, a} + 9'(LINE_WIDTH) - {1'b0, b};
            return (a >= b) ? (a - b) : t[7:0];
        end
    endfunction

    function automatic logic player_hit(input logic [7:0] x, input logic [7:0] g,
                                        input logic [7:0] nusiz, input logic [7:0] pos_raw,
                                        input logic refl);
        logic [2:0] ns;
        logic [1:0] sh;
        logic [5:0] span;
        logic [7:0] pos;
        logic [7:0] s;
        logic [7:0] d;
        logic [7:0] b8;
        logic [2:0] b;
        logic       found;
        logic       hit;
        begin
            ns    = nusiz[2:0];
            sh    = (ns == 3'd5) ? 2'd1 : ((ns == 3'd7) ? 2'd2 : 2'd0);
            span  = 6'd8 << sh;
            pos   = wrap_pos({1'b0, pos_raw});
            found = 1'b0;
            hit   = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (!found && COPY_OFFS[ns][k] != COPY_NONE) begin
                    s = wrap_pos({1'b0, pos} + {1'b0, COPY_OFFS[ns][k]});
                    d = wrap_diff(x, s);
                    if (d < {2'b00, span}) begin
                        found = 1'b1;
                        b8    = d >> sh;
                        b     = b8[2:0];
                        hit   = refl ? g[b] : g[3'd7 - b];
                    end
                end
            end
            return hit;
        end
    endfunction

    function automatic logic missile_hit(input logic [7:0] x, input logic [7:0] nusiz,
                                         input logic [7:0] pos_raw, input logic en);
        logic [2:0] ns;
        logic [3:0] size;
        logic [7:0] pos;
        logic [7:0] d;
        logic       hit;
        begin
            ns   = nusiz[2:0];
            size = 4'd1 << nusiz[5:4];
            pos  = wrap_pos({1'b0, pos_raw});
            hit  = 1'b0;
            // missile body itself does not wrap past the right edge
            for (int k = 0; k < 3; k++) begin
                if (COPY_OFFS[ns][k] != COPY_NONE) begin
                    d = wrap_diff(x, COPY_OFFS[ns][k]);
                    if (d >= pos && {1'b0, d} < ({1'b0, pos} + {5'b0, size})) begin
                        hit = 1'b1;
                    end
                end
            end
            return hit && en;
        end
    endfunction

    logic [7:0] w_ctrl;
    logic [5:0] w_h;
    logic [5:0] w_hm;
    logic [4:0] w_pf1_idx;
    logic [5:0] w_pf2_idx;
    logic [3:0] w_bl_size;
    logic [7:0] w_bl_pos;
    logic       w_pf;

    assign w_ctrl = i_regs[REG_CTRLPF];
    assign w_h    = 6'(i_x[7:2]);

    // right half repeats or mirrors the left half
    always_comb begin
        if (w_h > 6'd19) begin
            w_hm = w_ctrl[0] ? (6'd39 - w_h) : (w_h - 6'd20);
        end else begin
            w_hm = w_h;
        end
    end

    assign w_pf1_idx = 5'd11 - w_hm[4:0];
    assign w_pf2_idx = w_hm - 6'd12;

    always_comb begin
        if (w_hm < 6'd4) begin
            w_pf = i_regs[REG_PF0][{1'b1, w_hm[1:0]}];
        end else if (w_hm < 6'd12) begin
            w_pf = i_regs[REG_PF1][w_pf1_idx[2:0]];
        end else begin
            w_pf = i_regs[REG_PF2][w_pf2_idx[2:0]];
        end
    end

    assign w_bl_size = 4'd1 << w_ctrl[5:4];
    assign w_bl_pos  = wrap_pos({1'b0, i_regs[REG_POSBL]});

    assign o_hits.pf = w_pf;
    assign o_hits.bl = i_regs[REG_ENABL][1] && (i_x >= w_bl_pos)
                       && ({1'b0, i_x} < ({1'b0, w_bl_pos} + {5'b0, w_bl_size}));
    assign o_hits.p0 = player_hit(i_x, i_regs[REG_GRP0], i_regs[REG_NUSIZ0],
                                  i_regs[REG_POSP0], i_regs[REG_REFP0][3]);
    assign o_hits.p1 = player_hit(i_x, i_regs[REG_GRP1], i_regs[REG_NUSIZ1],
                                  i_regs[REG_POSP1], i_regs[REG_REFP1][3]);
    assign o_hits.m0 = missile_hit(i_x, i_regs[REG_NUSIZ0], i_regs[REG_POSM0],
                                   i_regs[REG_ENAM0][1] && !i_regs[REG_RESMP0][1]);
    assign o_hits.m1 = missile_hit(i_x, i_regs[REG_NUSIZ1], i_regs[REG_POSM1],
                                   i_regs[REG_ENAM1][1] && !i_regs[REG_RESMP1][1]);

endmodule

[rtl/core/vopc_compose.sv]
// color priority, blanking, palette lookup and collision pairs
// depends on vopc_pkg
module vopc_compose (
    input  vopc_pkg::t_obj_regs i_regs,
    input  logic [7:0]          i_x,
    input  vopc_pkg::t_hits     i_hits,
    output logic [7:0]          o_color_code,
    output logic [23:0]         o_rgb_color,
    output logic [14:0]         o_pairs
);
    import vopc_pkg::*;

    logic [7:0] w_ctrl;
    logic [7:0] w_pfcol;
    logic       w_pfbl;
    logic [7:0] w_code;

    assign w_ctrl = i_regs[REG_CTRLPF];
    assign w_pfbl = i_hits.pf || i_hits.bl;

    // score mode paints each half in its player's color
    always_comb begin
        if (w_ctrl[1]) begin
            w_pfcol = (i_x < 8'(HALF_WIDTH)) ? i_regs[REG_COLUP0] : i_regs[REG_COLUP1];
        end else begin
            w_pfcol = i_regs[REG_COLUPF];
        end
    end

    always_comb begin
        w_code = i_regs[REG_COLUBK];
        if (w_pfbl) begin
            w_code = w_pfcol;
        end
        if (i_hits.p1 || i_hits.m1) begin
            w_code = i_regs[REG_COLUP1];
        end
        if (i_hits.p0 || i_hits.m0) begin
            w_code = i_regs[REG_COLUP0];
        end
        if (w_pfbl && w_ctrl[2]) begin
            w_code = w_pfcol;
        end
        if (i_regs[REG_VBLANK][1]) begin
            w_code = BLANK_CODE;
        end
    end

    assign o_color_code = w_code;
    assign o_rgb_color  = PALETTE[w_code[7:1]];

    assign o_pairs = {
        i_hits.m0 && i_hits.m1,
        i_hits.p0 && i_hits.p1,
        i_hits.bl && i_hits.pf,
        i_hits.m1 && i_hits.bl,
        i_hits.m1 && i_hits.pf,
        i_hits.m0 && i_hits.bl,
        i_hits.m0 && i_hits.pf,
        i_hits.p1 && i_hits.bl,
        i_hits.p1 && i_hits.pf,
        i_hits.p0 && i_hits.bl,
        i_hits.p0 && i_hits.pf,
        i_hits.m1 && i_hits.p1,
        i_hits.m1 && i_hits.p0,
        i_hits.m0 && i_hits.p0,
        i_hits.m0 && i_hits.p1
    };

endmodule

[rtl/core/video_object_pixel_composer.sv]
// Video object pixel composer: composes one scanline pixel per transfer.
// Input channel i_item carries a mode: pixel tick (column in pixel_x), object
// register write (reg_index, write_data) or clear of the collision latches.
// Output channel o_result gives one result per input transfer, in order:
// color code, 24-bit RGB, the objects present and the fifteen collision latches.
// Writes and clears return zero color and hits with the latches after the step.
// An accepted item sits in an input register; its result moves into the output
// register once that register is free or being read; register writes land then.
// Throughput is one item per cycle while results are taken, set by the single
// compose stage between the input and output registers.
// When the receiver stalls, the output register holds its result and the
// input register takes one more item, then i_item.ready drops.
// Synchronous reset clears the object registers, the latches and both valids.
// Depends on vopc_pkg, vopc_if, vopc_regfile, vopc_object_hit, vopc_compose.
`include "video_object_pixel_composer_defines.svh"

module video_object_pixel_composer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vopc_item_if.sink            i_item,
    vopc_result_if.source        o_result
);
    import vopc_pkg::*;

    // input register
    logic        r_in_valid;
    t_mode       r_in_mode;
    logic [7:0]  r_in_pixel_x;
    logic [4:0]  r_in_reg_index;
    logic [7:0]  r_in_write_data;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_color_code;
    logic [23:0] r_out_rgb_color;
    logic [5:0]  r_out_object_hits;
    logic [14:0] r_out_collisions;

    logic [14:0] r_coll;
    logic [14:0] n_coll;

    logic        w_advance;
    logic        w_in_take;
    logic        w_tick;
    logic [7:0]  w_x;
    t_obj_regs   w_regs;
    t_hits       w_hits;
    logic [7:0]  w_color_code;
    logic [23:0] w_rgb_color;
    logic [14:0] w_pairs;

    assign w_advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;
    assign w_in_take = i_item.valid && i_item.ready;
    assign w_tick = (r_in_mode == MODE_TICK);
    assign w_x = wrap_pos({1'b0, r_in_pixel_x});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_mode       <= t_mode'(i_item.mode);
            r_in_pixel_x    <= i_item.pixel_x;
            r_in_reg_index  <= i_item.reg_index;
            r_in_write_data <= i_item.write_data;
        end
    end

    vopc_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_advance && r_in_mode == MODE_WRITE),
        .i_wr_index (r_in_reg_index),
        .i_wr_data  (r_in_write_data),
        .o_regs     (w_regs)
    );

    vopc_object_hit u_object_hit (
        .i_regs (w_regs),
        .i_x    (w_x),
        .o_hits (w_hits)
    );

    vopc_compose u_compose (
        .i_regs       (w_regs),
        .i_x          (w_x),
        .i_hits       (w_hits),
        .o_color_code (w_color_code),
        .o_rgb_color  (w_rgb_color),
        .o_pairs      (w_pairs)
    );

    always_comb begin
        n_coll = r_coll;
        if (r_in_mode == MODE_CLEAR) begin
            n_coll = '0;
        end else if (w_tick) begin
            n_coll = r_coll | w_pairs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll <= '0;
        end else if (w_advance) begin
            r_coll <= n_coll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_color_code  <= w_tick ? w_color_code : '0;
            r_out_rgb_color   <= w_tick ? w_rgb_color : '0;
            r_out_object_hits <= w_tick ? w_hits : '0;
            r_out_collisions  <= n_coll;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.color_code        = r_out_color_code;
    assign o_result.rgb_color         = r_out_rgb_color;
    assign o_result.object_hits       = r_out_object_hits;
    assign o_result.collision_latches = r_out_collisions;

    // latches only grow between clears
    `VOPC_ASSERT_NEXT(a_coll_sticky, i_clk, i_rst_n, w_advance && r_in_mode != MODE_CLEAR, (r_coll & $past(r_coll)) == $past(r_coll), "collision latch lost without a clear")

    `VOPC_ASSERT_NEXT(a_clear_result, i_clk, i_rst_n, w_advance && r_in_mode == MODE_CLEAR, o_result.collision_latches == '0, "clear result shows set latches")

    `VOPC_ASSERT_NEXT(a_blank_code, i_clk, i_rst_n, w_advance && w_tick && w_regs[REG_VBLANK][1], o_result.color_code == BLANK_CODE, "blanked pixel has wrong color code")

    `VOPC_ASSERT_SAME(a_out_matches_latch, i_clk, i_rst_n, r_out_valid && !r_in_valid, o_result.collision_latches == r_coll, "offered latches differ from state")

endmodule
